FILE: rtl/core/counted_multiset_table_assert.svh
// ---------------------------------------------------------------------------
// counted_multiset_table_assert.svh
// Assertion macros for the counted multiset table.
// Both expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef COUNTED_MULTISET_TABLE_ASSERT_SVH
`define COUNTED_MULTISET_TABLE_ASSERT_SVH

// same-cycle implication
`define CMT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cmt_pkg.sv
// ---------------------------------------------------------------------------
// cmt_pkg
// Shared constants, codes and types of the counted multiset table.
// ---------------------------------------------------------------------------
package cmt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int MODE_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 16;
    localparam int POS_W     = 4;
    localparam int STATUS_W  = 2;
    localparam int USED_W    = 5;
    localparam int TOTAL_W   = 64;
    localparam int FACTOR_W  = COUNT_W + 1;
    localparam int PROD_W    = VALUE_W + FACTOR_W;

    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BEYOND    = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        new_count;
        logic [POS_W-1:0]          position;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        count_out;
        logic signed [VALUE_W-1:0] value_out;
        logic [USED_W-1:0]         entries_used;
        logic signed [TOTAL_W-1:0] weighted_total;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic mul;
        logic apply;
        logic shift;
        logic shrink;
        logic read_pos;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              scan_done;
        logic              do_shift;
        logic              shift_done;
        logic              out_free;
    } ctl_stat_t;

endpackage

FILE: rtl/core/cmt_channels.sv
// ---------------------------------------------------------------------------
// cmt_channels
// Request and response channel interfaces, valid/ready handshake.
// ---------------------------------------------------------------------------
interface cmt_req_if import cmt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_W-1:0]        new_count;
    logic [POS_W-1:0]          position;

    modport source (output valid, output mode, output value, output new_count,
                    output position, input ready);
    modport sink   (input valid, input mode, input value, input new_count,
                    input position, output ready);
endinterface

interface cmt_rsp_if import cmt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count_out;
    logic signed [VALUE_W-1:0] value_out;
    logic [USED_W-1:0]         entries_used;
    logic signed [TOTAL_W-1:0] weighted_total;

    modport source (output valid, output status, output count_out, output value_out,
                    output entries_used, output weighted_total, input ready);
    modport sink   (input valid, input status, input count_out, input value_out,
                    input entries_used, input weighted_total, output ready);
endinterface

FILE: rtl/core/cmt_ram.sv
// ---------------------------------------------------------------------------
// cmt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/cmt_ctrl.sv
// ---------------------------------------------------------------------------
// cmt_ctrl
// Sequencer: scan for a match, apply the update, compact, or read a position; respond.
// ---------------------------------------------------------------------------
module cmt_ctrl import cmt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  ctl_stat_t st,
    output ctl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_APPLY = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (st.mode inside {[MODE_ADD:MODE_LOOKUP]})
                begin
                    cmd.scan = 1'b1;
                    if (st.scan_done)
                    begin
                        state_next = S_MUL;
                    end
                end
                else if (st.mode == MODE_READ)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = st.do_shift ? S_SHIFT : S_DONE;
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (st.shift_done)
                begin
                    cmd.shrink = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.read_pos = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/cmt_datapath.sv
// ---------------------------------------------------------------------------
// cmt_datapath
// Entry RAM, scan pointer, match capture, weighted total and result register.
// ---------------------------------------------------------------------------
module cmt_datapath import cmt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  req_t      req_data,
    input  ctl_cmd_t  cmd,
    output ctl_stat_t st,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_t      rsp_data
);

    req_t                       item_reg;
    logic [STATUS_W-1:0]        status_reg;
    logic [CNT_W-1:0]           entry_total_reg;
    logic signed [TOTAL_W-1:0]  total_reg;
    logic [CNT_W-1:0]           ptr_reg;
    logic                       pend_reg;
    logic [IDX_W-1:0]           pend_idx_reg;
    logic                       found_reg;
    logic [IDX_W-1:0]           hit_idx_reg;
    logic [COUNT_W-1:0]         hit_count_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       out_valid_reg;
    rsp_t                       out_reg;

    entry_t                     rd_entry;
    logic                       ram_wr_en;
    logic [IDX_W-1:0]           ram_wr_addr;
    entry_t                     ram_wr_data;
    logic                       ram_rd_en;
    logic [IDX_W-1:0]           ram_rd_addr;

    logic                       ptr_live;
    logic                       table_full;
    logic                       count_sat;
    logic                       pos_ok;
    logic                       load_pos_ok;
    logic                       scan_issue;
    logic                       shift_issue;
    logic                       hit;
    logic                       append;
    logic signed [FACTOR_W-1:0] factor;
    logic [STATUS_W-1:0]        mul_status;
    logic                       out_free;
    rsp_t                       result;

    cmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_entry)
    );

    assign ptr_live    = (ptr_reg < entry_total_reg);
    assign table_full  = (entry_total_reg == CNT_W'(ENTRIES));
    assign count_sat   = (hit_count_reg == COUNT_MAX);
    assign pos_ok      = (32'(item_reg.position) < 32'(entry_total_reg));
    assign load_pos_ok = (32'(req_data.position) < 32'(entry_total_reg));
    assign scan_issue  = cmd.scan && ptr_live && !found_reg;
    assign shift_issue = cmd.shift && ptr_live;
    assign hit         = cmd.scan && pend_reg && !found_reg &&
                         (rd_entry.value == item_reg.value);
    assign append      = (item_reg.mode == MODE_ADD) && !found_reg && !table_full;
    assign out_free    = !out_valid_reg || rsp_ready;

    // signed count change applied to value for the running total
    always_comb
    begin
        factor     = '0;
        mul_status = ST_OK;
        case (item_reg.mode)
            MODE_ADD:
            begin
                if (found_reg)
                begin
                    factor = count_sat ? FACTOR_W'(0) : FACTOR_W'(1);
                end
                else if (table_full)
                begin
                    mul_status = ST_FULL;
                end
                else
                begin
                    factor = FACTOR_W'(1);
                end
            end
            MODE_REMOVE:
            begin
                if (found_reg)
                begin
                    factor = -$signed({1'b0, hit_count_reg});
                end
                else
                begin
                    mul_status = ST_NOT_FOUND;
                end
            end
            MODE_SET:
            begin
                if (found_reg)
                begin
                    factor = $signed({1'b0, item_reg.new_count}) -
                             $signed({1'b0, hit_count_reg});
                end
                else
                begin
                    mul_status = ST_NOT_FOUND;
                end
            end
            MODE_LOOKUP:
            begin
                if (!found_reg)
                begin
                    mul_status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                factor = '0;
            end
        endcase
    end

    always_comb
    begin
        ram_rd_en   = scan_issue || shift_issue;
        ram_rd_addr = ptr_reg[IDX_W-1:0];
        if (cmd.read_pos && pos_ok)
        begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = IDX_W'(item_reg.position);
        end
    end

    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = hit_idx_reg;
        ram_wr_data = rd_entry;
        if (cmd.shift && pend_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pend_idx_reg - IDX_W'(1);
        end
        else if (cmd.apply)
        begin
            case (item_reg.mode)
                MODE_ADD:
                begin
                    if (found_reg && !count_sat)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = '{value: item_reg.value,
                                        count: hit_count_reg + COUNT_W'(1)};
                    end
                    else if (append)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = entry_total_reg[IDX_W-1:0];
                        ram_wr_data = '{value: item_reg.value, count: COUNT_W'(1)};
                    end
                end
                MODE_SET:
                begin
                    if (found_reg)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = '{value: item_reg.value, count: item_reg.new_count};
                    end
                end
                default:
                begin
                    ram_wr_en = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        result                = '0;
        result.status         = status_reg;
        result.entries_used   = USED_W'(entry_total_reg);
        result.weighted_total = total_reg;
        if (item_reg.mode == MODE_LOOKUP && found_reg)
        begin
            result.count_out = hit_count_reg;
        end
        else if (item_reg.mode == MODE_READ && status_reg == ST_OK)
        begin
            result.count_out = rd_entry.count;
            result.value_out = rd_entry.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req_data;
            status_reg <= (req_data.mode == MODE_READ && !load_pos_ok) ? ST_BEYOND : ST_OK;
        end
        else if (cmd.mul)
        begin
            status_reg <= mul_status;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(item_reg.value) * PROD_W'(factor);
        end
        if (hit)
        begin
            hit_idx_reg   <= pend_idx_reg;
            hit_count_reg <= rd_entry.count;
        end
        pend_idx_reg <= ptr_reg[IDX_W-1:0];
        if (cmd.emit)
        begin
            out_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_total_reg <= '0;
            total_reg       <= '0;
            ptr_reg         <= '0;
            pend_reg        <= 1'b0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pend_reg <= scan_issue || shift_issue;
            if (cmd.load)
            begin
                ptr_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.apply)
            begin
                ptr_reg <= CNT_W'(hit_idx_reg) + CNT_W'(1);
            end
            else if (scan_issue || shift_issue)
            begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end
            if (hit)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.apply)
            begin
                total_reg <= total_reg +
                             {{(TOTAL_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                if (append)
                begin
                    entry_total_reg <= entry_total_reg + CNT_W'(1);
                end
            end
            else if (cmd.shrink)
            begin
                entry_total_reg <= entry_total_reg - CNT_W'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign st.mode       = item_reg.mode;
    assign st.scan_done  = found_reg || (!ptr_live && !pend_reg);
    assign st.do_shift   = (item_reg.mode == MODE_REMOVE) && found_reg;
    assign st.shift_done = !ptr_live && !pend_reg;
    assign st.out_free   = out_free;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

FILE: rtl/core/counted_multiset_table.sv
// ---------------------------------------------------------------------------
// counted_multiset_table
// Insertion-ordered table of distinct values with occurrence counts and a
// running sum of value times count.
// Add, set and lookup scan the RAM one entry per cycle until a match or the
//   end of the table; unused modes go straight to the response.
// Remove then compacts the entries after the match; read position reads directly.
// One transaction in flight; the next is taken while a result waits.
// Reset clears the entry count, running total and control state; RAM
//   contents are left as they are.
// ---------------------------------------------------------------------------
`include "counted_multiset_table_assert.svh"

module counted_multiset_table import cmt_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    cmt_req_if.sink   req,
    cmt_rsp_if.source rsp
);

    req_t      req_data;
    rsp_t      rsp_data;
    ctl_cmd_t  cmd;
    ctl_stat_t st;
    logic      ctl_ready;

    assign req_data.mode      = req.mode;
    assign req_data.value     = req.value;
    assign req_data.new_count = req.new_count;
    assign req_data.position  = req.position;
    assign req.ready          = ctl_ready;

    cmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ctl_ready),
        .st        (st),
        .cmd       (cmd)
    );

    cmt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .st        (st),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp_data)
    );

    assign rsp.status         = rsp_data.status;
    assign rsp.count_out      = rsp_data.count_out;
    assign rsp.value_out      = rsp_data.value_out;
    assign rsp.entries_used   = rsp_data.entries_used;
    assign rsp.weighted_total = rsp_data.weighted_total;

    `CMT_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "second transaction taken while busy")
    `CMT_ASSERT_SAME(a_full_at_capacity, rsp.valid && rsp.status == ST_FULL, rsp.entries_used == USED_W'(ENTRIES), "full reported below capacity")
    `CMT_ASSERT_SAME(a_beyond_empty, rsp.valid && rsp.status == ST_BEYOND, rsp.count_out == '0 && rsp.value_out == '0, "beyond result carries data")
    `CMT_ASSERT_NEXT(a_emit_held, cmd.emit, rsp.valid, "result lost after emit")

endmodule
